// ===== sv/rrs_pkg.sv =====
// Shared constants and request/result types for the round-robin scheduler.
`timescale 1ns / 1ps

package rrs_pkg;

    localparam int MAX_PROCS = 16;
    localparam int TIME_BITS = 16;

    localparam int IDX_W  = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CNT_W  = $clog2(MAX_PROCS + 1);
    localparam int ID_W   = 4;
    localparam int SVC_W  = 10;
    localparam int Q_W    = 8;
    localparam int OUT_TW = 16;

    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 40;
    localparam int OUT_USER_W = 3;

    typedef enum logic {
        MODE_ARRIVE = 1'b0,
        MODE_TICK   = 1'b1
    } mode_t;

    typedef struct packed {
        mode_t             mode;
        logic [ID_W-1:0]   proc_id;
        logic [SVC_W-1:0]  svc_ticks;
    } req_t;

    typedef struct packed {
        logic              busy_res;
        logic [ID_W-1:0]   run_id;
        logic              completed;
        logic [OUT_TW-1:0] finish_time;
        logic [OUT_TW-1:0] turnaround;
        logic              rejected;
    } res_t;

    typedef struct packed {
        logic fire;
        logic load;
    } step_t;

endpackage

// ===== sv/rrs_in_stage.sv =====
// Input register holding one accepted request.
`timescale 1ns / 1ps

module rrs_in_stage
    import rrs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic accept,
    input  logic advance,
    input  req_t req_in,
    output logic valid,
    output req_t req_out
);

    logic valid_reg;
    logic valid_next;
    req_t req_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (advance)
        begin
            valid_next = 1'b0;
        end
        if (accept)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req_in;
        end
    end

    assign valid   = valid_reg;
    assign req_out = req_reg;

endmodule

// ===== sv/rrs_sched.sv =====
// Ready queue, held process, arrival stamps, time counter and per-request result logic.
`timescale 1ns / 1ps

module rrs_sched
    import rrs_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  step_t          step,
    input  req_t           req,
    input  logic [Q_W-1:0] quantum,
    output res_t           res
);

    localparam int ID_SLOTS = 1 << ID_W;
    localparam logic [TIME_BITS-1:0] TIME_MAX = '1;
    localparam logic [Q_W-1:0] SLICE_MAX = '1;

    logic [ID_W-1:0]      ready_ids_reg [MAX_PROCS];
    logic [SVC_W-1:0]     ready_rem_reg [MAX_PROCS];
    logic [TIME_BITS-1:0] stamp_reg     [ID_SLOTS];

    logic [IDX_W-1:0]     head_reg, head_next;
    logic [IDX_W-1:0]     tail_reg, tail_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [Q_W-1:0]       slice_reg, slice_next;
    logic                 held_valid_reg, held_valid_next;
    logic [ID_W-1:0]      held_id_reg, held_id_next;
    logic [SVC_W-1:0]     held_rem_reg, held_rem_next;
    logic [TIME_BITS-1:0] now_reg, now_next;

    logic                 is_tick;
    logic                 arrive_ok;
    logic                 push_held;
    logic                 bypass;
    logic                 run;
    logic                 done;
    logic                 preempt;
    logic [CNT_W:0]       used_cnt;
    logic [CNT_W-1:0]     eff_count;
    logic [IDX_W-1:0]     tail_inc;
    logic [IDX_W-1:0]     head_inc;
    logic [ID_W-1:0]      head_id;
    logic [SVC_W-1:0]     head_rem;
    logic [SVC_W-1:0]     rem_dec;
    logic [Q_W-1:0]       slice_inc;
    logic [TIME_BITS-1:0] fin;
    logic [TIME_BITS-1:0] stamp;
    logic [TIME_BITS-1:0] ta;

    always_comb
    begin
        is_tick   = (req.mode == MODE_TICK);
        used_cnt  = {1'b0, count_reg} + (CNT_W+1)'(held_valid_reg);
        arrive_ok = !is_tick && (used_cnt < (CNT_W+1)'(MAX_PROCS));
        push_held = is_tick && held_valid_reg && (count_reg < CNT_W'(MAX_PROCS));
        eff_count = count_reg + CNT_W'(push_held);
        bypass    = push_held && (count_reg == '0);
        tail_inc  = (tail_reg == IDX_W'(MAX_PROCS - 1)) ? '0 : tail_reg + 1'b1;
        head_inc  = (head_reg == IDX_W'(MAX_PROCS - 1)) ? '0 : head_reg + 1'b1;
        head_id   = bypass ? held_id_reg  : ready_ids_reg[head_reg];
        head_rem  = bypass ? held_rem_reg : ready_rem_reg[head_reg];
        run       = is_tick && (eff_count != '0);
        rem_dec   = (head_rem == '0) ? '0 : head_rem - 1'b1;
        slice_inc = (slice_reg == SLICE_MAX) ? SLICE_MAX : slice_reg + 1'b1;
        done      = (rem_dec == '0);
        preempt   = !done && (slice_inc >= quantum);
        fin       = (now_reg == TIME_MAX) ? TIME_MAX : now_reg + 1'b1;
        stamp     = stamp_reg[head_id];
        ta        = (fin >= stamp) ? fin - stamp : '0;

        res             = '0;
        res.rejected    = !is_tick && !arrive_ok;
        res.busy_res    = run;
        res.run_id      = run ? head_id : '0;
        res.completed   = run && done;
        res.finish_time = (run && done) ? OUT_TW'(fin) : '0;
        res.turnaround  = (run && done) ? OUT_TW'(ta) : '0;

        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        slice_next      = slice_reg;
        held_valid_next = held_valid_reg;
        held_id_next    = held_id_reg;
        held_rem_next   = held_rem_reg;
        now_next        = now_reg;

        if (arrive_ok)
        begin
            tail_next  = tail_inc;
            count_next = count_reg + 1'b1;
        end
        if (is_tick)
        begin
            now_next   = fin;
            count_next = eff_count;
            if (push_held)
            begin
                tail_next       = tail_inc;
                held_valid_next = 1'b0;
            end
            if (run)
            begin
                slice_next = slice_inc;
                if (done || preempt)
                begin
                    head_next  = head_inc;
                    count_next = eff_count - 1'b1;
                    slice_next = '0;
                end
                if (preempt)
                begin
                    held_valid_next = 1'b1;
                    held_id_next    = head_id;
                    held_rem_next   = rem_dec;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg       <= '0;
            tail_reg       <= '0;
            count_reg      <= '0;
            slice_reg      <= '0;
            held_valid_reg <= 1'b0;
            held_id_reg    <= '0;
            held_rem_reg   <= '0;
            now_reg        <= '0;
        end
        else if (step.fire)
        begin
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            count_reg      <= count_next;
            slice_reg      <= slice_next;
            held_valid_reg <= held_valid_next;
            held_id_reg    <= held_id_next;
            held_rem_reg   <= held_rem_next;
            now_reg        <= now_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step.fire)
        begin
            if (arrive_ok)
            begin
                ready_ids_reg[tail_reg] <= req.proc_id;
                ready_rem_reg[tail_reg] <= req.svc_ticks;
                stamp_reg[req.proc_id]  <= now_reg;
            end
            if (push_held)
            begin
                ready_ids_reg[tail_reg] <= held_id_reg;
                if (!bypass)
                begin
                    ready_rem_reg[tail_reg] <= held_rem_reg;
                end
            end
            if (run)
            begin
                ready_rem_reg[head_reg] <= rem_dec;
            end
        end
    end

    a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, count_reg} + (CNT_W+1)'(held_valid_reg)) <= (CNT_W+1)'(MAX_PROCS))
        else $error("queue plus held process exceeds capacity");

    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (head_reg == tail_reg))
        else $error("empty queue with mismatched pointers");

    a_held_slice: assert property (@(posedge clk) disable iff (!rst_n)
        held_valid_reg |-> (slice_reg == '0))
        else $error("held process with nonzero slice count");

    a_done_slice: assert property (@(posedge clk) disable iff (!rst_n)
        (step.fire && res.completed) |=> (slice_reg == '0))
        else $error("slice not cleared after completion");

    a_time_mono: assert property (@(posedge clk) disable iff (!rst_n)
        step.fire |=> (now_reg >= $past(now_reg)))
        else $error("time counter went backward");

endmodule

// ===== sv/rrs_out_stage.sv =====
// Result register toward the output channel.
`timescale 1ns / 1ps

module rrs_out_stage
    import rrs_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  step_t step,
    input  logic  taken,
    input  res_t  res_in,
    output logic  valid,
    output res_t  res_out
);

    logic valid_reg;
    logic valid_next;
    res_t res_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (taken)
        begin
            valid_next = 1'b0;
        end
        if (step.load)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step.load)
        begin
            res_reg <= res_in;
        end
    end

    assign valid   = valid_reg;
    assign res_out = res_reg;

endmodule

// ===== sv/round_robin_scheduler_core.sv =====
// Top level of the tick-driven round-robin scheduler.
// Usage:
//   s_axis carries one request: tuser = mode (0 arrival, 1 tick),
//   tdata = proc_id and svc_ticks. Every request yields exactly one
//   result on m_axis: tuser = busy_res, completed, rejected flags,
//   tdata = run_id, finish_time, turnaround.
//   cfg_valid/cfg_data write the quantum; cfg_ready is always high.
//   Write it only while no request is in flight.
//   Throughput: one request per cycle while m_axis is not stalled;
//   the queue, held process, slice, time counter and one stamp
//   entry are all the state a request touches, computed
//   combinationally between the input and result registers.
//   When m_axis stalls, the result register holds, the input register
//   fills, then s_axis_tready drops until the result is taken.
//   Reset clears the queue, held process, slice and time counter and
//   sets the quantum to 1; no clearing pass is needed.
`timescale 1ns / 1ps

module round_robin_scheduler_core
    import rrs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // proc_id[3:0], svc_ticks[13:4], zero pad
    input  logic                  s_axis_tuser,   // mode
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // run_id[3:0], finish_time[19:4], turnaround[35:20]
    output logic [OUT_USER_W-1:0] m_axis_tuser,   // busy_res[0], completed[1], rejected[2]
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [Q_W-1:0]        cfg_data
);

    logic           in_valid;
    logic           out_valid;
    logic           advance;
    logic           accept;
    req_t           req_in;
    req_t           req_cur;
    res_t           res_cur;
    res_t           res_out;
    step_t          step;
    logic [Q_W-1:0] quantum_reg;

    assign advance       = in_valid && (!out_valid || m_axis_tready);
    assign s_axis_tready = !in_valid || advance;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign step.fire     = advance;
    assign step.load     = advance;
    assign cfg_ready     = 1'b1;

    always_comb
    begin
        req_in           = '0;
        req_in.mode      = mode_t'(s_axis_tuser);
        req_in.proc_id   = s_axis_tdata[ID_W-1:0];
        req_in.svc_ticks = s_axis_tdata[ID_W+SVC_W-1:ID_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quantum_reg <= Q_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            quantum_reg <= cfg_data;
        end
    end

    rrs_in_stage u_in (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .advance (advance),
        .req_in  (req_in),
        .valid   (in_valid),
        .req_out (req_cur)
    );

    rrs_sched u_sched (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .req     (req_cur),
        .quantum (quantum_reg),
        .res     (res_cur)
    );

    rrs_out_stage u_out (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .taken   (m_axis_tready),
        .res_in  (res_cur),
        .valid   (out_valid),
        .res_out (res_out)
    );

    assign m_axis_tvalid = out_valid;
    assign m_axis_tdata  = {4'b0000, res_out.turnaround, res_out.finish_time, res_out.run_id};
    assign m_axis_tuser  = {res_out.rejected, res_out.completed, res_out.busy_res};

endmodule
